// ===== src/pcm_frame_to_dac_sample_defines.svh =====
// Assertion macros used by the top-level design file.
`ifndef PCM_FRAME_TO_DAC_SAMPLE_DEFINES_SVH
`define PCM_FRAME_TO_DAC_SAMPLE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define PCMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked in reset as well
`define PCMD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCMD_ASSERT(label, prop, msg)
`define PCMD_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== src/pcmd_pkg.sv =====
package pcmd_pkg;

  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 12;
  localparam int VOL_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int HELD_N     = 3;
  localparam int POS_W      = 2;
  localparam int LEN_W      = 3;

  localparam logic [SAMPLE_W-1:0] MIDSCALE = 12'd2048;
  localparam logic [SAMPLE_W-1:0] DAC_MAX  = 12'd4095;
  localparam logic [VOL_W-1:0]    UNITY_Q8 = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIXTEEN_BIT = 2'd0,
    REG_STEREO      = 2'd1,
    REG_VOLUME      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic sixteen_bit;
    logic stereo;
  } fmt_t;

  // one gathered frame; the last byte is the one that closed it
  typedef struct packed {
    fmt_t                          fmt;
    logic [HELD_N-1:0][BYTE_W-1:0] held;
    logic [BYTE_W-1:0]             last;
  } frame_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len;
  } asm_stat_t;

endpackage

// ===== src/pcmd_byte_if.sv =====
interface pcmd_byte_if;
  import pcmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/pcmd_sample_if.sv =====
interface pcmd_sample_if;
  import pcmd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] dac_sample;

  modport source (output valid, output dac_sample, input ready);
  modport sink   (input valid, input dac_sample, output ready);
endinterface

// ===== src/pcmd_frame_asm.sv =====
module pcmd_frame_asm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcmd_pkg::fmt_t             fmt,
  input  logic                       clr,
  input  logic                       byte_valid,
  input  logic [pcmd_pkg::BYTE_W-1:0] byte_data,
  output logic                       byte_ready,
  output logic                       frm_valid,
  output pcmd_pkg::frame_t           frm,
  input  logic                       frm_ready,
  output pcmd_pkg::asm_stat_t        stat
);
  import pcmd_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] held_r [HELD_N];
  logic              frm_valid_r;
  frame_t            frm_r;
  logic [LEN_W-1:0]  len;
  logic              take;
  logic              last_byte;

  always_comb begin
    len = fmt.sixteen_bit ? 3'd2 : 3'd1;
    if (fmt.stereo) begin
      len = {len[1:0], 1'b0};
    end
  end

  assign byte_ready = !frm_valid_r || frm_ready;
  assign take       = byte_valid && byte_ready;
  assign last_byte  = ({1'b0, pos_r} + 3'd1) >= len;

  always_comb begin
    pos_nxt = pos_r;
    if (clr) begin
      pos_nxt = '0;
    end else if (take) begin
      pos_nxt = last_byte ? '0 : pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      frm_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (byte_ready) begin
        frm_valid_r <= take && last_byte && !clr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !last_byte) begin
      held_r[pos_r] <= byte_data;
    end
    if (take && last_byte) begin
      frm_r.fmt  <= fmt;
      for (int i = 0; i < HELD_N; i++) begin
        frm_r.held[i] <= held_r[i];
      end
      frm_r.last <= byte_data;
    end
  end

  assign frm_valid = frm_valid_r;
  assign frm       = frm_r;
  assign stat.pos  = pos_r;
  assign stat.len  = len;
endmodule

// ===== src/pcmd_decode.sv =====
module pcmd_decode (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          frm_valid,
  input  pcmd_pkg::frame_t              frm,
  output logic                          frm_ready,
  output logic                          smp_valid,
  output logic [pcmd_pkg::SAMPLE_W-1:0] smp,
  input  logic                          smp_ready
);
  import pcmd_pkg::*;

  logic                smp_valid_r;
  logic [SAMPLE_W-1:0] smp_r, code;
  logic [BYTE_W:0]     sum8;
  logic [BYTE_W-1:0]   x8;
  logic [15:0]         l16, r16, v16;
  logic [16:0]         sum16, adj16;

  always_comb begin
    // 8-bit unsigned: average of the channels (mono averages with itself)
    x8   = frm.fmt.stereo ? frm.held[0] : frm.last;
    sum8 = {1'b0, x8} + {1'b0, frm.last};

    // 16-bit signed little endian
    if (frm.fmt.stereo) begin
      l16 = {frm.held[1], frm.held[0]};
      r16 = {frm.last, frm.held[2]};
    end else begin
      l16 = {frm.last, frm.held[0]};
      r16 = l16;
    end
    sum16 = {l16[15], l16} + {r16[15], r16};
    // halve toward zero: bump negative sums by one before the shift
    adj16 = sum16 + {16'd0, sum16[16]};
    v16   = frm.fmt.stereo ? adj16[16:1] : l16;

    if (frm.fmt.sixteen_bit) begin
      // +32768 flips the sign bit, then keep the top 12 bits
      code = {~v16[15], v16[14:4]};
    end else begin
      code = {sum8[BYTE_W:1], 4'd0};
    end
  end

  assign frm_ready = !smp_valid_r || smp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (frm_ready) begin
      smp_valid_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      smp_r <= code;
    end
  end

  assign smp_valid = smp_valid_r;
  assign smp       = smp_r;
endmodule

// ===== src/pcmd_scale.sv =====
module pcmd_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pcmd_pkg::VOL_W-1:0]    volume,
  input  logic                          smp_valid,
  input  logic [pcmd_pkg::SAMPLE_W-1:0] smp,
  output logic                          smp_ready,
  output logic                          res_valid,
  output logic [pcmd_pkg::SAMPLE_W-1:0] res,
  input  logic                          res_ready
);
  import pcmd_pkg::*;

  logic                res_valid_r;
  logic [SAMPLE_W-1:0] res_r, code;
  logic signed [12:0]  ctr;
  logic signed [9:0]   vol_s;
  logic signed [22:0]  prod, adj;
  logic signed [14:0]  q, lvl;

  always_comb begin
    ctr   = signed'({1'b0, smp}) - signed'({1'b0, MIDSCALE});
    vol_s = signed'({2'b00, volume[7:0]});
    prod  = ctr * vol_s;
    // divide by 256 toward zero
    adj   = prod + signed'({15'd0, {8{prod[22]}}});
    q     = adj[22:8];
    lvl   = q + signed'({3'b000, MIDSCALE});
    if (volume >= UNITY_Q8) begin
      code = smp;
    end else if (lvl[14]) begin
      code = '0;
    end else if (lvl > signed'({3'b000, DAC_MAX})) begin
      code = DAC_MAX;
    end else begin
      code = lvl[SAMPLE_W-1:0];
    end
  end

  assign smp_ready = !res_valid_r || res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (smp_ready) begin
      res_valid_r <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_ready && smp_valid) begin
      res_r <= code;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;
endmodule

// ===== src/pcm_frame_to_dac_sample.sv =====
// A frame's closing beat passes the frame gather, format decode and volume scale registers.
// Throughput: one beat per cycle, stalled only by output ready; at most one sample per beat.
// Three register stages: frame gather, format decode, volume multiply and clamp.
// Reset (rst_n low at a clock edge): frame position and all stage valids clear,
// registers go to 16-bit, mono, unity volume. Held bytes keep whatever they had.
`include "pcm_frame_to_dac_sample_defines.svh"

module pcm_frame_to_dac_sample (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmd_pkg::CFG_DATA_W-1:0] cfg_data,
  pcmd_byte_if.sink                       in_byte,
  pcmd_sample_if.source                   out_sample
);
  import pcmd_pkg::*;

  fmt_t                fmt_r;
  logic [VOL_W-1:0]    volume_r;
  logic                fmt_clr;
  logic                frm_valid, frm_ready;
  frame_t              frm;
  asm_stat_t           asm_stat;
  logic                smp_valid, smp_ready;
  logic [SAMPLE_W-1:0] smp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r.sixteen_bit <= 1'b1;
      fmt_r.stereo      <= 1'b0;
      volume_r          <= UNITY_Q8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIXTEEN_BIT: fmt_r.sixteen_bit <= cfg_data[0];
        REG_STEREO:      fmt_r.stereo      <= cfg_data[0];
        REG_VOLUME:      volume_r          <= cfg_data[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  // any write to a format register throws away a part-gathered frame
  assign fmt_clr = cfg_we && (cfg_index == REG_SIXTEEN_BIT || cfg_index == REG_STEREO);

  pcmd_frame_asm u_asm (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt        (fmt_r),
    .clr        (fmt_clr),
    .byte_valid (in_byte.valid),
    .byte_data  (in_byte.data_byte),
    .byte_ready (in_byte.ready),
    .frm_valid  (frm_valid),
    .frm        (frm),
    .frm_ready  (frm_ready),
    .stat       (asm_stat)
  );

  pcmd_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm       (frm),
    .frm_ready (frm_ready),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready)
  );

  pcmd_scale u_scl (
    .clk       (clk),
    .rst_n     (rst_n),
    .volume    (volume_r),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready),
    .res_valid (out_sample.valid),
    .res       (out_sample.dac_sample),
    .res_ready (out_sample.ready)
  );

  `PCMD_ASSERT_RST(a_rst_idle, !rst_n |=> !out_sample.valid && !frm_valid && !smp_valid,
    "pipeline not empty after reset")
  `PCMD_ASSERT(a_pos_in_frame, {1'b0, asm_stat.pos} < asm_stat.len,
    "frame position beyond frame length")
  `PCMD_ASSERT(a_fmt_clr, fmt_clr |=> asm_stat.pos == '0,
    "format write did not restart the frame")
  `PCMD_ASSERT(a_out_source, $rose(out_sample.valid) |-> $past(smp_valid),
    "sample appeared without a decoded sample behind it")
endmodule

// ===== tb/pcm_frame_to_dac_sample_tb.sv =====
module pcm_frame_to_dac_sample_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmd_pkg::*;

  localparam int PIPE_LAT     = 3;
  localparam int S16_OFFSET   = 32768;
  localparam int RANDOM_BYTES = 1300;
  localparam int MAX_PRINTED  = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pcmd_byte_if   byte_ch();
  pcmd_sample_if sample_ch();

  pcm_frame_to_dac_sample dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_byte    (byte_ch),
    .out_sample (sample_ch)
  );

  // predictor state, mirrors the block's registers and frame buffer
  fmt_t              fmt_now;
  logic [VOL_W-1:0]  vol_now;
  logic [POS_W-1:0]  frame_pos;
  logic [BYTE_W-1:0] held [HELD_N];

  logic [SAMPLE_W-1:0] due_samples [$];

  int  errors;
  int  bytes_in;
  int  samples_checked;
  int  frames_by_fmt [4];
  bit  src_idle;
  bit  sink_idle;
  int  hold_req;
  int  sink_wait;
  int  sink_draw;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic logic [SAMPLE_W-1:0] pcm_code(input fmt_t f,
      input logic [BYTE_W-1:0] b0, b1, b2, b3);
    int l;
    int r;
    int avg;
    if (!f.sixteen_bit) begin
      l = int'(b0);
      r = f.stereo ? int'(b1) : int'(b0);
      avg = (l + r) / 2;
      return SAMPLE_W'(avg << 4);
    end
    l = int'($signed({b1, b0}));
    r = int'($signed({b3, b2}));
    // signed int division truncates toward zero
    avg = f.stereo ? (l + r) / 2 : l;
    return SAMPLE_W'((avg + S16_OFFSET) >> 4);
  endfunction

  function automatic logic [SAMPLE_W-1:0] apply_volume(input logic [SAMPLE_W-1:0] s,
      input logic [VOL_W-1:0] v);
    int c;
    if (v >= UNITY_Q8)
      return s;
    c = (int'(s) - int'(MIDSCALE)) * int'(v) / int'(UNITY_Q8);
    c += int'(MIDSCALE);
    if (c < 0)
      return '0;
    if (c > int'(DAC_MAX))
      return DAC_MAX;
    return c[SAMPLE_W-1:0];
  endfunction

  function automatic void gather_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] frm [4];
    int len;
    len = (fmt_now.sixteen_bit ? 2 : 1) << fmt_now.stereo;
    bytes_in++;
    if (frame_pos + 1 < len) begin
      held[frame_pos] = b;
      frame_pos++;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      frm[i] = 8'h00;
      if (i < len - 1)
        frm[i] = held[i];
    end
    frm[len-1] = b;
    frame_pos = '0;
    frames_by_fmt[fmt_now]++;
    due_samples.push_back(apply_volume(pcm_code(fmt_now, frm[0], frm[1], frm[2], frm[3]),
                                       vol_now));
  endfunction

  // wait until no sample is in flight; a part-gathered frame stays in the block
  task automatic settle();
    byte_ch.valid <= 1'b0;
    while (due_samples.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
      input logic [CFG_DATA_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SIXTEEN_BIT: begin
        fmt_now.sixteen_bit = value[0];
        frame_pos = '0;
      end
      REG_STEREO: begin
        fmt_now.stereo = value[0];
        frame_pos = '0;
      end
      REG_VOLUME: vol_now = value[VOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic sixteen, input logic two_ch);
    write_reg(REG_SIXTEEN_BIT, CFG_DATA_W'(sixteen));
    write_reg(REG_STEREO, CFG_DATA_W'(two_ch));
  endtask

  // valid is only dropped when a gap follows, so back-to-back beats keep it high
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    gather_byte(b);
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] corner [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
    if ($urandom_range(0, 3) == 0)
      return corner[$urandom_range(0, 5)];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2:    return UNITY_Q8;
      3:       return 9'd255;
      4:       return 9'd128;
      5:       return VOL_W'($urandom_range(257, 511));
      default: return VOL_W'($urandom_range(1, 255));
    endcase
  endfunction

  // format registers only look at bit 0; fill the rest with junk
  function automatic logic [CFG_DATA_W-1:0] with_noise(input logic v);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[0] = v;
    return d;
  endfunction

  // result side pacing: per-beat stall draw, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      sample_ch.ready <= 1'b0;
      hold_req--;
    end else if (sink_wait > 0) begin
      sample_ch.ready <= 1'b0;
      sink_wait--;
    end else if (sample_ch.ready && sample_ch.valid) begin
      sink_draw = sink_idle ? $urandom_range(0, 11) : 0;
      if (sink_draw > 0) begin
        sample_ch.ready <= 1'b0;
        sink_wait = sink_draw - 1;
      end
    end else begin
      sample_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (rst_n && sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) begin
      samples_checked++;
      if (due_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d", sample_ch.dac_sample));
      end else begin
        want = due_samples.pop_front();
        if (sample_ch.dac_sample !== want)
          report_mismatch($sformatf("sample %0d: dac_sample %0d, expected %0d",
                                    samples_checked, sample_ch.dac_sample, want));
      end
    end
  end

  task automatic test_reset_defaults();
    // 16-bit mono, unity gain out of reset
    send_byte(8'hFF); send_byte(8'h7F);
    send_byte(8'h00); send_byte(8'h80);
  endtask

  task automatic test_eight_bit();
    set_format(1'b0, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    set_format(1'b0, 1'b1);
    send_byte(8'hFF); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'hFE);
  endtask

  task automatic test_sixteen_bit_stereo();
    set_format(1'b1, 1'b1);
    // -1 and 0 average to zero, not -1
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h7F); send_byte(8'hFF); send_byte(8'h7F);
  endtask

  task automatic test_volume();
    set_format(1'b0, 1'b0);
    write_reg(REG_VOLUME, 9'd0);
    send_byte(8'hFF);
    write_reg(REG_VOLUME, 9'd1);
    send_byte(8'h00);
    write_reg(REG_VOLUME, 9'd255);
    send_byte(8'h01);
    // anything at or above unity passes through
    write_reg(REG_VOLUME, 9'd511);
    send_byte(8'hFF);
    write_reg(REG_VOLUME, UNITY_Q8);
  endtask

  task automatic test_format_change_mid_frame();
    set_format(1'b1, 1'b1);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
    write_reg(REG_STEREO, 9'd0);
    send_byte(8'h34); send_byte(8'h12);
  endtask

  task automatic test_volume_write_mid_frame();
    send_byte(8'h00);
    write_reg(REG_VOLUME, 9'd128);
    send_byte(8'hC0);
    write_reg(REG_VOLUME, UNITY_Q8);
  endtask

  task automatic test_unmapped_register();
    send_byte(8'h55);
    write_reg(REG_UNMAPPED, 9'h1FF);
    send_byte(8'hAA);
  endtask

  task automatic test_backpressure();
    set_format(1'b0, 1'b0);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 300;
    repeat (80) send_byte(pick_byte());
    // sender pauses until the backlog has drained
    byte_ch.valid <= 1'b0;
    while (due_samples.size() != 0)
      @(posedge clk);
    src_idle = 1'b1;
    repeat (20) send_byte(pick_byte());
  endtask

  task automatic test_random_stream();
    int sent;
    int phase;
    int n;
    logic [1:0] fmt_code;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BYTES) begin
      fmt_code  = phase[1:0];
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      write_reg(REG_SIXTEEN_BIT, with_noise(fmt_code[1]));
      write_reg(REG_STEREO, with_noise(fmt_code[0]));
      write_reg(REG_VOLUME, pick_volume());
      n = $urandom_range(30, 70);
      repeat (n) begin
        if (frame_pos != 0 && $urandom_range(0, 49) == 0) begin
          // rewriting a format register drops the partial frame
          if ($urandom_range(0, 1))
            write_reg(REG_STEREO, with_noise(fmt_now.stereo));
          else
            write_reg(REG_SIXTEEN_BIT, with_noise(fmt_now.sixteen_bit));
        end else if ($urandom_range(0, 79) == 0) begin
          write_reg(REG_VOLUME, pick_volume());
        end
        send_byte(pick_byte());
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    int n;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    sample_ch.ready   = 1'b0;
    errors            = 0;
    bytes_in          = 0;
    samples_checked   = 0;
    hold_req          = 0;
    sink_wait         = 0;
    src_idle          = 1'b1;
    sink_idle         = 1'b1;
    foreach (frames_by_fmt[i]) frames_by_fmt[i] = 0;
    fmt_now.sixteen_bit = 1'b1;
    fmt_now.stereo      = 1'b0;
    vol_now             = UNITY_Q8;
    frame_pos           = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_eight_bit();
    test_sixteen_bit_stereo();
    test_volume();
    test_format_change_mid_frame();
    test_volume_write_mid_frame();
    test_unmapped_register();
    test_backpressure();
    test_random_stream();

    byte_ch.valid <= 1'b0;
    for (n = 0; n < 5000 && due_samples.size() != 0; n++)
      @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (due_samples.size() != 0)
      report_mismatch($sformatf("%0d samples never arrived", due_samples.size()));

    $display("Run: %0d bytes in, %0d samples checked, %0d mismatches", bytes_in,
             samples_checked, errors);
    $display("Frames: 8b mono %0d, 8b stereo %0d, 16b mono %0d, 16b stereo %0d",
             frames_by_fmt[0], frames_by_fmt[1], frames_by_fmt[2], frames_by_fmt[3]);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
